// ----- hdl/mrc_pkg.sv -----
package mrc_pkg;

  localparam int MAX_FRAME_BYTES = 256;
  localparam int COUNT_W = $clog2(MAX_FRAME_BYTES + 1);

  localparam logic [15:0] CRC_START = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;

  localparam logic [7:0] RESET_ADDRESS    = 8'h01;
  localparam logic [7:0] RESET_FUNCTION   = 8'h04;
  localparam logic [7:0] RESET_BYTE_COUNT = 8'h04;

  localparam int CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ADDRESS    = 2'd0,
    REG_FUNCTION   = 2'd1,
    REG_BYTE_COUNT = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_HEADER    = 2'd1,
    STATUS_CRC       = 2'd2,
    STATUS_TOO_SHORT = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] address;
    logic [7:0] function_code;
    logic [7:0] byte_count;
  } mrc_cfg_t;

  typedef struct packed {
    logic               present;
    logic signed [31:0] counter;
    status_t            status;
  } mrc_result_t;

  localparam int OUT_W = 40;

endpackage

// ----- hdl/modbus_response_checker.sv -----
// channel  | direction | handshake          | payload
// s_       | in        | s_tvalid/s_tready  | s_tdata = data_byte, s_tlast = last_byte
// m_       | out       | m_tvalid/m_tready  | m_tdata = status, counter_value, present
// cfg_     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// one byte per cycle; the crc step, header compares and judgment sit in one
// combinational path from the frame state to the result register.
// a frame's result appears the cycle after its last byte transfers.
// reset clears the frame state and loads the default header values.
// input stalls only while a result waits and m_tready is low.
module modbus_response_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,   // [7:0] data_byte
  input  logic                               s_tlast,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [1:0] status, [33:2] counter_value, [34] counter_present, [39:35] zero
  output logic [mrc_pkg::OUT_W-1:0]          m_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mrc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [7:0]                         cfg_data
);
  import mrc_pkg::*;

  mrc_cfg_t    cfg;
  mrc_result_t result;
  logic        room;
  logic        accept;

  assign cfg_ready = 1'b1;
  assign s_tready  = room;
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.address       <= RESET_ADDRESS;
      cfg.function_code <= RESET_FUNCTION;
      cfg.byte_count    <= RESET_BYTE_COUNT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ADDRESS:    cfg.address       <= cfg_data;
        REG_FUNCTION:   cfg.function_code <= cfg_data;
        REG_BYTE_COUNT: cfg.byte_count    <= cfg_data;
        default: ;
      endcase
    end
  end

  mrc_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (s_tdata),
    .last_byte (s_tlast),
    .cfg       (cfg),
    .result    (result)
  );

  mrc_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (accept && s_tlast),
    .result   (result),
    .room     (room),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ----- hdl/mrc_crc8.sv -----
module mrc_crc8 (
  input  logic [15:0] crc,
  input  logic [7:0]  data,
  output logic [15:0] crc_next
);
  import mrc_pkg::*;

  // one byte of the reflected crc-16, bit at a time
  always_comb begin
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_next = c;
  end

endmodule

// ----- hdl/mrc_frame.sv -----
module mrc_frame (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  input  mrc_pkg::mrc_cfg_t cfg,
  output mrc_pkg::mrc_result_t result
);
  import mrc_pkg::*;

  logic [15:0]        crc_acc;
  logic [COUNT_W-1:0] bytes_seen;
  logic [7:0]         held0;
  logic [7:0]         held1;
  logic [31:0]        capture;
  logic               header_ok;

  logic [15:0]        crc_fed;
  logic [15:0]        crc_next;
  logic [COUNT_W-1:0] bytes_next;
  logic [31:0]        capture_next;
  logic               header_next;
  logic               present;
  status_t            status;

  mrc_crc8 u_crc (
    .crc      (crc_acc),
    .data     (held0),
    .crc_next (crc_fed)
  );

  always_comb begin
    // the two newest bytes are held back, so the crc trails by two
    crc_next = (bytes_seen >= COUNT_W'(2)) ? crc_fed : crc_acc;
    bytes_next = (bytes_seen < COUNT_W'(MAX_FRAME_BYTES)) ?
                 bytes_seen + COUNT_W'(1) : bytes_seen;
    header_next = header_ok;
    if (bytes_seen == COUNT_W'(0) && data_byte != cfg.address) header_next = 1'b0;
    if (bytes_seen == COUNT_W'(1) && data_byte != cfg.function_code) header_next = 1'b0;
    if (bytes_seen == COUNT_W'(2) && data_byte != cfg.byte_count) header_next = 1'b0;
    capture_next = capture;
    if (bytes_seen >= COUNT_W'(3) && bytes_seen <= COUNT_W'(6)) begin
      capture_next = {capture[23:0], data_byte};
    end

    priority if (bytes_next < COUNT_W'(5)) begin
      status = STATUS_TOO_SHORT;
    end else if (!header_next) begin
      status = STATUS_HEADER;
    end else if (held1 != crc_next[7:0] || data_byte != crc_next[15:8]) begin
      status = STATUS_CRC;
    end else begin
      status = STATUS_OK;
    end

    present = (status == STATUS_OK) && (bytes_next >= COUNT_W'(9));
    result.status  = status;
    result.present = present;
    result.counter = present ? $signed(capture_next) : 32'sd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_acc    <= CRC_START;
      bytes_seen <= '0;
      held0      <= '0;
      held1      <= '0;
      capture    <= '0;
      header_ok  <= 1'b1;
    end else if (accept) begin
      if (last_byte) begin
        crc_acc    <= CRC_START;
        bytes_seen <= '0;
        held0      <= '0;
        held1      <= '0;
        capture    <= '0;
        header_ok  <= 1'b1;
      end else begin
        crc_acc    <= crc_next;
        bytes_seen <= bytes_next;
        held0      <= held1;
        held1      <= data_byte;
        capture    <= capture_next;
        header_ok  <= header_next;
      end
    end
  end

endmodule

// ----- hdl/mrc_out.sv -----
module mrc_out (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load,
  input  mrc_pkg::mrc_result_t     result,
  output logic                     room,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [mrc_pkg::OUT_W-1:0] m_tdata
);
  import mrc_pkg::*;

  mrc_result_t held;

  assign room     = !m_tvalid || m_tready;
  assign m_tdata  = {{(OUT_W - $bits(mrc_result_t)){1'b0}}, held};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule
